>>> hdl/rcq_pkg.sv
// ----------------------------------------------------------------------------
// rcq_pkg
// Shared types and constants for the reversible circular queue.
// ----------------------------------------------------------------------------
package rcq_pkg;

    // Word and result field widths
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 2;

    // Operation codes carried by each input transfer
    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SIZE = 2'd2,
        OP_REV  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-operation outcome passed from the pointer unit to the result pipe
    typedef struct packed {
        t_status status;
        logic    mem_read;
    } t_op_res;

endpackage

>>> hdl/rcq_ram.sv
// ----------------------------------------------------------------------------
// rcq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rcq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: hold the last word while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rcq_ctrl.sv
// ----------------------------------------------------------------------------
// rcq_ctrl
// Head/tail pointers, fill count and direction bit. Decodes each operation
// into at most one memory access and the result status.
// ----------------------------------------------------------------------------
module rcq_ctrl
    import rcq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  t_op                      i_op,
    output logic                     o_we,
    output logic                     o_re,
    output logic [$clog2(DEPTH)-1:0] o_addr,
    output t_op_res                  o_res,
    output logic [$clog2(DEPTH)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_count, n_count;
    logic          r_rev, n_rev;
    logic          full, empty;

    // Wrap-around pointer steps
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? LAST : p - AW'(1);
    endfunction

    assign full  = (r_count == LAST);
    assign empty = (r_count == '0);

    // Decode operation against the current pointers
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_rev        = r_rev;
        o_we         = 1'b0;
        o_re         = 1'b0;
        o_addr       = r_tail;
        o_res.status = ST_OK;
        o_res.mem_read = 1'b0;
        case (i_op)
            OP_ENQ: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else if (!r_rev) begin
                    o_we    = i_fire;
                    o_addr  = r_tail;
                    n_tail  = ptr_inc(r_tail);
                    n_count = r_count + AW'(1);
                end else begin
                    o_we    = i_fire;
                    o_addr  = ptr_dec(r_head);
                    n_head  = ptr_dec(r_head);
                    n_count = r_count + AW'(1);
                end
            end
            OP_DEQ: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else if (!r_rev) begin
                    o_re           = i_fire;
                    o_res.mem_read = 1'b1;
                    o_addr         = r_head;
                    n_head         = ptr_inc(r_head);
                    n_count        = r_count - AW'(1);
                end else begin
                    o_re           = i_fire;
                    o_res.mem_read = 1'b1;
                    o_addr         = ptr_dec(r_tail);
                    n_tail         = ptr_dec(r_tail);
                    n_count        = r_count - AW'(1);
                end
            end
            OP_SIZE: begin
                n_count = r_count;
            end
            OP_REV: begin
                n_rev = !r_rev;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Advance pointer state on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_fire) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    assign o_count = n_count;

endmodule

>>> hdl/reversible_circular_queue.sv
// ----------------------------------------------------------------------------
// reversible_circular_queue
// Circular FIFO of signed words holding up to DEPTH-1 entries, with enqueue,
// dequeue, size and constant-time order reversal.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-------------------------------
//   in      | input     | i_valid, o_stall | i_op, i_value_in
//   out     | output    | o_valid, i_stall | o_value_out, o_count, o_status
//
// One operation is taken every cycle while o_stall is low. Its result is
// registered in the memory access stage and then in the output register
// before it is presented on the out channel. The queue storage is a
// DEPTH x 32 RAM with registered read.
// Synchronous active-low reset clears pointers, count, direction and the
// pipe; the RAM is not cleared. A stall on the output backs up the pipe
// and raises o_stall once both stages are full.
// ----------------------------------------------------------------------------
module reversible_circular_queue
    import rcq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_op,
    input  logic signed [WORD_W-1:0]   i_value_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [WORD_W-1:0]   o_value_out,
    output logic [COUNT_W-1:0]         o_count,
    output logic [STATUS_W-1:0]        o_status
);

    localparam int AW = $clog2(DEPTH);

    logic                   fire;
    logic                   s1_move;
    logic                   mem_we;
    logic                   mem_re;
    logic [AW-1:0]          mem_addr;
    logic [WORD_W-1:0]      mem_rdata;
    t_op_res                op_res;
    logic [AW-1:0]          next_count;
    logic [AW+COUNT_W-1:0]  count_ext;

    logic                   r_s1_valid;
    t_op_res                r_s1_res;
    logic [COUNT_W-1:0]     r_s1_count;

    logic                   r_out_valid;
    logic [WORD_W-1:0]      r_out_value;
    logic [COUNT_W-1:0]     r_out_count;
    logic [STATUS_W-1:0]    r_out_status;

    // Pipe flow control
    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_move;
    assign fire    = i_valid && !o_stall;

    rcq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_op    (t_op'(i_op)),
        .o_we    (mem_we),
        .o_re    (mem_re),
        .o_addr  (mem_addr),
        .o_res   (op_res),
        .o_count (next_count)
    );

    rcq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (i_value_in),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    // Mask the fill level to the result field width
    assign count_ext = {{COUNT_W{1'b0}}, next_count};

    // Memory access stage: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Memory access stage: payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_res   <= op_res;
            r_s1_count <= count_ext[COUNT_W-1:0];
        end
    end

    // Output register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload, zero the word unless a dequeue read it
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_value  <= r_s1_res.mem_read ? mem_rdata : '0;
            r_out_count  <= r_s1_count;
            r_out_status <= r_s1_res.status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value_out = r_out_value;
    assign o_count     = r_out_count;
    assign o_status    = r_out_status;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reversible circular queue. A short table of
// directed operations covers empty and full queues, order reversal and the
// word extremes. A long random run follows, with fill and drain phases.
// Every result is compared field by field against its directed expectation or an in-bench queue model.
// Input bursts, output stalls and long receiver hold-offs exercise the
// valid/stall handshake on both channels.
// ----------------------------------------------------------------------------
module tb;
    import rcq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RAND_OPS    = 800;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        t_status                  status;
    } t_queue_result;

    typedef struct {
        t_op           op;
        logic [31:0]   word;
        int            reps;
        bit            typed;
        t_queue_result res;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [1:0]               i_op;
    logic signed [WORD_W-1:0] i_value_in;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [WORD_W-1:0] o_value_out;
    logic [COUNT_W-1:0]       o_count;
    logic [STATUS_W-1:0]      o_status;

    // Queue model state
    logic [WORD_W-1:0] slot_mem [DEPTH];
    int                head_ptr;
    int                tail_ptr;
    bit                rev_mode;

    t_queue_result pending_results[$];
    t_stim_row     dir_rows[$];

    int error_count   = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int hold_left     = 0;
    int next_hold_at  = 200;
    int stall_mode    = 0;
    int n_enq_ok      = 0;
    int n_full        = 0;
    int n_deq_ok      = 0;
    int n_empty       = 0;
    int n_rev         = 0;
    int n_size        = 0;

    reversible_circular_queue #(.DEPTH(DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_out (o_value_out),
        .o_count     (o_count),
        .o_status    (o_status)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Apply one operation to the queue model and return its result
    function automatic t_queue_result apply_queue_op(input t_op op,
                                                     input logic [WORD_W-1:0] word);
        t_queue_result res;
        int            fill;
        res.value  = '0;
        res.status = ST_OK;
        fill = (tail_ptr + DEPTH - head_ptr) % DEPTH;
        case (op)
            OP_ENQ: begin
                if (fill >= DEPTH - 1) begin
                    res.status = ST_FULL;
                    n_full++;
                end else if (!rev_mode) begin
                    slot_mem[tail_ptr] = word;
                    tail_ptr = (tail_ptr + 1) % DEPTH;
                    n_enq_ok++;
                end else begin
                    head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
                    slot_mem[head_ptr] = word;
                    n_enq_ok++;
                end
            end
            OP_DEQ: begin
                if (fill == 0) begin
                    res.status = ST_EMPTY;
                    n_empty++;
                end else if (!rev_mode) begin
                    res.value = slot_mem[head_ptr];
                    head_ptr = (head_ptr + 1) % DEPTH;
                    n_deq_ok++;
                end else begin
                    tail_ptr = (tail_ptr + DEPTH - 1) % DEPTH;
                    res.value = slot_mem[tail_ptr];
                    n_deq_ok++;
                end
            end
            OP_SIZE: n_size++;
            default: begin
                rev_mode = !rev_mode;
                n_rev++;
            end
        endcase
        res.count = COUNT_W'((tail_ptr + DEPTH - head_ptr) % DEPTH);
        return res;
    endfunction

    function automatic t_stim_row stim_row(input t_op op, input logic [31:0] word,
                                           input int reps, input bit typed,
                                           input logic [31:0] e_value, input int e_count,
                                           input t_status e_status);
        t_stim_row r;
        r.op         = op;
        r.word       = word;
        r.reps       = reps;
        r.typed      = typed;
        r.res.value  = e_value;
        r.res.count  = COUNT_W'(e_count);
        r.res.status = e_status;
        return r;
    endfunction

    // Word mix biased towards the extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // Operation mix for a fill, drain or balanced phase
    function automatic t_op pick_op(input int bias);
        int roll;
        int enq_w;
        int deq_w;
        roll  = $urandom_range(0, 99);
        enq_w = (bias == 0) ? 60 : (bias == 1) ? 20 : 40;
        deq_w = (bias == 0) ? 20 : (bias == 1) ? 60 : 40;
        if (roll < enq_w)
            return OP_ENQ;
        else if (roll < enq_w + deq_w)
            return OP_DEQ;
        else if (roll < enq_w + deq_w + 10)
            return OP_SIZE;
        else
            return OP_REV;
    endfunction

    // Offer one operation, wait for its transfer, then log the expectation
    task automatic send_op(input t_op op, input logic [31:0] word, input bit typed,
                           input t_queue_result typed_res);
        t_queue_result predicted;
        int            gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_op       <= op;
        i_value_in <= word;
        do @(posedge i_clk); while (o_stall);
        predicted = apply_queue_op(op, word);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Check each output transfer and pick the next stall level
    always @(posedge i_clk) begin
        t_queue_result exp_res;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: value_out %0d count %0d status %0d",
                           o_value_out, o_count, o_status);
                    error_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_value_out !== exp_res.value) begin
                        $error("value_out: expected %0d, got %0d", exp_res.value, o_value_out);
                        error_count++;
                    end
                    if (o_count !== exp_res.count) begin
                        $error("count: expected %0d, got %0d", exp_res.count, o_count);
                        error_count++;
                    end
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, o_status);
                        error_count++;
                    end
                end
            end
            if (cycle_count % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            if (hold_left == 0 && results_seen >= next_hold_at) begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 350;
            end
            // Long hold-off first, then the current stall pattern
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 9) < 6);
                    default: i_stall <= cycle_count[0];
                endcase
            end
        end
    end

    initial begin
        t_op           rnd_op;
        int            bias;
        t_queue_result no_res;
        no_res     = '0;
        bias       = 2;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_op       = OP_SIZE;
        i_value_in = '0;
        head_ptr   = 0;
        tail_ptr   = 0;
        rev_mode   = 1'b0;

        // Directed operations: empty, reversal, extremes, full in both orders
        dir_rows.push_back(stim_row(OP_SIZE, 32'h0, 1, 1, 32'h0, 0, ST_OK));
        dir_rows.push_back(stim_row(OP_DEQ, 32'h1234_5678, 1, 1, 32'h0, 0, ST_EMPTY));
        dir_rows.push_back(stim_row(OP_REV, 32'h0, 1, 1, 32'h0, 0, ST_OK));
        dir_rows.push_back(stim_row(OP_ENQ, 32'h5, 1, 1, 32'h0, 1, ST_OK));
        dir_rows.push_back(stim_row(OP_REV, 32'h0, 1, 1, 32'h0, 1, ST_OK));
        dir_rows.push_back(stim_row(OP_DEQ, 32'h0, 1, 1, 32'h5, 0, ST_OK));
        dir_rows.push_back(stim_row(OP_ENQ, 32'h8000_0000, 1, 1, 32'h0, 1, ST_OK));
        dir_rows.push_back(stim_row(OP_ENQ, 32'h7FFF_FFFF, 1, 1, 32'h0, 2, ST_OK));
        dir_rows.push_back(stim_row(OP_ENQ, 32'h0, 1, 1, 32'h0, 3, ST_OK));
        dir_rows.push_back(stim_row(OP_ENQ, 32'hFFFF_FFFF, 1, 1, 32'h0, 4, ST_OK));
        dir_rows.push_back(stim_row(OP_DEQ, 32'h0, 1, 1, 32'h8000_0000, 3, ST_OK));
        dir_rows.push_back(stim_row(OP_REV, 32'h0, 1, 0, 32'h0, 0, ST_OK));
        dir_rows.push_back(stim_row(OP_DEQ, 32'h0, 1, 0, 32'h0, 0, ST_OK));
        dir_rows.push_back(stim_row(OP_ENQ, 32'h5555_5555, 13, 0, 32'h0, 0, ST_OK));
        dir_rows.push_back(stim_row(OP_ENQ, 32'hDEAD_BEEF, 1, 1, 32'h0, 15, ST_FULL));
        dir_rows.push_back(stim_row(OP_SIZE, 32'h0, 1, 1, 32'h0, 15, ST_OK));
        dir_rows.push_back(stim_row(OP_REV, 32'h0, 1, 0, 32'h0, 0, ST_OK));
        dir_rows.push_back(stim_row(OP_ENQ, 32'hAAAA_AAAA, 1, 1, 32'h0, 15, ST_FULL));
        dir_rows.push_back(stim_row(OP_DEQ, 32'h0, 15, 0, 32'h0, 0, ST_OK));
        dir_rows.push_back(stim_row(OP_DEQ, 32'h0, 1, 1, 32'h0, 0, ST_EMPTY));
        dir_rows.push_back(stim_row(OP_ENQ, 32'hAAAA_AAAA, 1, 0, 32'h0, 0, ST_OK));
        dir_rows.push_back(stim_row(OP_DEQ, 32'h0, 1, 0, 32'h0, 0, ST_OK));

        // Hold reset, then release it
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            for (int k = 0; k < dir_rows[i].reps; k++)
                send_op(dir_rows[i].op, dir_rows[i].word + 32'(k), dir_rows[i].typed,
                        dir_rows[i].res);

        // Random phases alternate between filling, draining and a balanced mix
        for (int n = 0; n < RAND_OPS; n++) begin
            if (n % 40 == 0)
                bias = $urandom_range(0, 2);
            rnd_op = pick_op(bias);
            send_op(rnd_op, pick_word(), 0, no_res);
        end
        i_valid <= 1'b0;

        // Drain outstanding results, then allow for the pipe latency
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("tb: %0d results checked; enqueue ok %0d, full %0d, dequeue ok %0d",
                 results_seen, n_enq_ok, n_full, n_deq_ok);
        $display("tb: empty %0d, reverse %0d, size %0d, errors %0d",
                 n_empty, n_rev, n_size, error_count);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> reversible_circular_queue.f
hdl/rcq_pkg.sv
hdl/rcq_ram.sv
hdl/rcq_ctrl.sv
hdl/reversible_circular_queue.sv
tb/tb.sv
